/* hdl/pfr_pkg.sv */
// Package: geometry, refresh command bytes, input kinds and sequencer states.
package pfr_pkg;

  localparam int WIDTH       = 128;
  localparam int HEIGHT      = 32;
  localparam int PAGES       = HEIGHT / 8;
  localparam int ROWS        = PAGES * 8;
  localparam int STORE_BYTES = WIDTH * PAGES;
  localparam int HEAD_BYTES  = 3;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int IDX_W  = $clog2(WIDTH + HEAD_BYTES);
  localparam int COL_W  = 9;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h04;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [1:0] {
    KIND_SET_PIXEL = 2'd0,
    KIND_WRITE8    = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_REFRESH   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_RD,
    ST_PIX_WR,
    ST_REF_RD,
    ST_REF_OUT
  } state_t;

endpackage

/* hdl/page_framebuffer_refresh.sv */
// Page-major 1-bit frame store with pixel writes, clear and a byte-serial refresh stream.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+-----------------------------
//  request  | kind, pos_x, pos_y, color, pixel_bits         | start high, busy low at edge
//  result   | out_byte, is_data, frame_last                 | strobe high for one cycle
//
// Steps: set pixel reads, then does a modify-write; an eight-pixel write makes eight
// read/write passes through the store; a refresh byte is read, then registered, with
// the strobe in the cycle after ST_REF_OUT (it may overlap the next request); clear
// zeroes one store byte per cycle.
// Reset starts a clearing pass over all STORE_BYTES bytes (512 at defaults); busy stays high.
// The receiver cannot stall: each result is shown for exactly one cycle.
module page_framebuffer_refresh
  import pfr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       kind,
  input  logic [7:0]       pos_x,
  input  logic [5:0]       pos_y,
  input  logic             color,
  input  logic [7:0]       pixel_bits,
  output logic             strobe,
  output logic [7:0]       out_byte,
  output logic             is_data,
  output logic             frame_last
);

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rd_data;

  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr;
  logic              is_eight;
  logic [7:0]        x_base;
  logic [5:0]        row;
  logic              lit_color;
  logic [7:0]        bits;
  logic [2:0]        step;
  logic [PAGE_W-1:0] ref_page;
  logic [IDX_W-1:0]  ref_idx;

  logic              accept;
  logic              row_ok;
  logic [COL_W-1:0]  col;
  logic              col_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [IDX_W-1:0]  ref_col;
  logic [ADDR_W-1:0] ref_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              we;
  logic              pix_lit;
  logic [7:0]        bit_mask;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign row_ok = {1'b0, pos_y} < 7'(ROWS);

  assign col      = {1'b0, x_base} + COL_W'(step);
  assign col_ok   = col < COL_W'(WIDTH);
  assign pix_addr = ADDR_W'(row[5:3]) * ADDR_W'(WIDTH) + ADDR_W'(col);
  assign ref_col  = ref_idx - IDX_W'(HEAD_BYTES);
  assign ref_addr = ADDR_W'(ref_page) * ADDR_W'(WIDTH) + ADDR_W'(ref_col);
  assign pix_lit  = is_eight ? bits[3'd7 - step] : lit_color;
  assign bit_mask = 8'd1 << row[2:0];

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    wr_addr    = pix_addr;
    wr_data    = pix_lit ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    rd_addr    = (state == ST_REF_RD) ? ref_addr : pix_addr;
    case (state)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_addr;
        wr_data = 8'd0;
        if (clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_SET_PIXEL, KIND_WRITE8: begin
              if (row_ok) begin
                state_next = ST_PIX_RD;
              end
            end
            KIND_CLEAR:   state_next = ST_CLEAR;
            KIND_REFRESH: state_next = ST_REF_RD;
            default:      state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX_RD: state_next = ST_PIX_WR;
      ST_PIX_WR: begin
        // drop pixels past the right edge
        we = col_ok;
        if (!is_eight || step == 3'd7) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_PIX_RD;
        end
      end
      ST_REF_RD:  state_next = ST_REF_OUT;
      ST_REF_OUT: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      ref_page <= '0;
      ref_idx  <= '0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_REF_OUT);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end else begin
        clr_addr <= '0;
      end
      // advance the refresh cursor, wrap at page end and after the last page
      if (state == ST_REF_OUT) begin
        if (ref_idx == IDX_W'(WIDTH + HEAD_BYTES - 1)) begin
          ref_idx <= '0;
          if (ref_page == PAGE_W'(PAGES - 1)) begin
            ref_page <= '0;
          end else begin
            ref_page <= ref_page + PAGE_W'(1);
          end
        end else begin
          ref_idx <= ref_idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_eight  <= (kind == KIND_WRITE8);
      x_base    <= pos_x;
      row       <= pos_y;
      lit_color <= color;
      bits      <= pixel_bits;
      step      <= 3'd0;
    end else if (state == ST_PIX_WR) begin
      step <= step + 3'd1;
    end
    if (state == ST_REF_OUT) begin
      if (ref_idx == IDX_W'(0)) begin
        out_byte   <= CMD_PAGE_BASE + 8'(ref_page);
        is_data    <= 1'b0;
        frame_last <= 1'b0;
      end else if (ref_idx == IDX_W'(1)) begin
        out_byte   <= CMD_COL_LOW;
        is_data    <= 1'b0;
        frame_last <= 1'b0;
      end else if (ref_idx == IDX_W'(2)) begin
        out_byte   <= CMD_COL_HIGH;
        is_data    <= 1'b0;
        frame_last <= 1'b0;
      end else begin
        out_byte   <= rd_data;
        is_data    <= 1'b1;
        frame_last <= (ref_page == PAGE_W'(PAGES - 1)) &&
                      (ref_col == IDX_W'(WIDTH - 1));
      end
    end
  end

endmodule

/* bench/page_framebuffer_refresh_chk.sv */
// Checker: shadows the frame store and refresh cursor, compares every strobed link byte.
`timescale 1ns / 100ps
module page_framebuffer_refresh_chk
  import pfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [1:0] kind,
  input  logic [7:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic       color,
  input  logic [7:0] pixel_bits,
  input  logic       strobe,
  input  logic [7:0] out_byte,
  input  logic       is_data,
  input  logic       frame_last,
  output int         mismatches,
  output int         outstanding,
  output int         bytes_checked,
  output int         frames_seen
);

  typedef struct packed {
    logic [7:0] value;
    logic       data;
    logic       last;
  } link_byte_t;

  logic [7:0]        shadow_store [STORE_BYTES];
  logic [PAGE_W-1:0] cur_page;
  int unsigned       cur_pos;
  link_byte_t        pending_bytes [$];

  function automatic void paint(int unsigned x, int unsigned y, logic lit);
    int unsigned addr;
    // drop anything off screen, including rows past the last full page
    if (x >= WIDTH || y >= ROWS) return;
    addr = x + (y / 8) * WIDTH;
    shadow_store[addr][y % 8] = lit;
  endfunction

  function automatic link_byte_t next_link_byte();
    link_byte_t  b;
    int unsigned col;
    b.data = 1'b0;
    b.last = 1'b0;
    if (cur_pos == 0) b.value = CMD_PAGE_BASE + 8'(cur_page);
    else if (cur_pos == 1) b.value = CMD_COL_LOW;
    else if (cur_pos == 2) b.value = CMD_COL_HIGH;
    else begin
      col = cur_pos - HEAD_BYTES;
      b.value = shadow_store[col + cur_page * WIDTH];
      b.data = 1'b1;
      b.last = (cur_page == PAGE_W'(PAGES - 1)) && (col == WIDTH - 1);
    end
    // advance the cursor, wrapping at the end of the page and of the frame
    cur_pos++;
    if (cur_pos >= WIDTH + HEAD_BYTES) begin
      cur_pos = 0;
      cur_page = (cur_page == PAGE_W'(PAGES - 1)) ? '0 : cur_page + 1'b1;
    end
    return b;
  endfunction

  always @(posedge clk) begin
    link_byte_t want;
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      cur_page = '0;
      cur_pos = 0;
      pending_bytes.delete();
      mismatches = 0;
      bytes_checked = 0;
      frames_seen = 0;
    end else begin
      // a strobe here belongs to an earlier request, so compare before accepting a new one
      if (strobe) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %h data %b last %b",
                   $time, out_byte, is_data, frame_last);
          mismatches++;
        end else begin
          want = pending_bytes.pop_front();
          bytes_checked++;
          if (frame_last) frames_seen++;
          if (out_byte !== want.value) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.value, out_byte);
            mismatches++;
          end
          if (is_data !== want.data) begin
            $display("%0t: is_data expected %b actual %b", $time, want.data, is_data);
            mismatches++;
          end
          if (frame_last !== want.last) begin
            $display("%0t: frame_last expected %b actual %b", $time, want.last, frame_last);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        case (kind_t'(kind))
          KIND_SET_PIXEL: paint(pos_x, pos_y, color);
          KIND_WRITE8: begin
            if (pos_y < ROWS)
              for (int i = 0; i < 8; i++) paint(pos_x + i, pos_y, pixel_bits[7 - i]);
          end
          KIND_CLEAR: begin
            // cursor stays where it is
            foreach (shadow_store[i]) shadow_store[i] = '0;
          end
          KIND_REFRESH: pending_bytes.push_back(next_link_byte());
          default: ;
        endcase
      end
    end
    outstanding = pending_bytes.size();
  end

endmodule

/* bench/page_framebuffer_refresh_tb.sv */
// Testbench top: drives pixel, clear and refresh requests into the framebuffer and gives the verdict.
`timescale 1ns / 100ps
module page_framebuffer_refresh_tb;
  import pfr_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] kind = KIND_SET_PIXEL;
  logic [7:0] pos_x = '0;
  logic [5:0] pos_y = '0;
  logic       color = 1'b0;
  logic [7:0] pixel_bits = '0;
  logic       strobe;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_last;

  int mismatches;
  int outstanding;
  int bytes_checked;
  int frames_seen;

  int idle_pct = 0;
  int total_sent = 0;
  int sent_by_kind [4] = '{0, 0, 0, 0};
  int phase_idle [4] = '{0, 58, 0, 19};

  page_framebuffer_refresh dut (
    .clk, .rst, .start, .busy, .kind, .pos_x, .pos_y, .color, .pixel_bits,
    .strobe, .out_byte, .is_data, .frame_last
  );

  page_framebuffer_refresh_chk chk (
    .clk, .rst, .start, .busy, .kind, .pos_x, .pos_y, .color, .pixel_bits,
    .strobe, .out_byte, .is_data, .frame_last,
    .mismatches, .outstanding, .bytes_checked, .frames_seen
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic issue(input logic [1:0] k, input logic [7:0] x, input logic [5:0] y,
                       input logic c, input logic [7:0] bits);
    int gap;
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    kind <= k;
    pos_x <= x;
    pos_y <= y;
    color <= c;
    pixel_bits <= bits;
    // hold the request until an edge with busy low
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_by_kind[k]++;
    total_sent++;
  endtask

  task automatic pull_bytes(input int n);
    repeat (n) issue(KIND_REFRESH, 8'($urandom), 6'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic draw_request();
    logic [7:0] x;
    logic [5:0] y;
    x = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(WIDTH - 1));
    y = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(ROWS - 1));
    if ($urandom_range(1) == 0) begin
      issue(KIND_SET_PIXEL, x, y, 1'($urandom), 8'($urandom));
    end else begin
      // lean on the right edge now and then to exercise clipping
      if ($urandom_range(3) == 0) x = 8'($urandom_range(WIDTH - 1, WIDTH - 8));
      issue(KIND_WRITE8, x, y, 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners, off-screen drops, clipping, both colors
    issue(KIND_SET_PIXEL, 8'd0,   6'd0,  1'b1, 8'hFF);
    issue(KIND_SET_PIXEL, 8'd127, 6'd31, 1'b1, 8'h00);
    issue(KIND_SET_PIXEL, 8'd128, 6'd5,  1'b1, 8'h5A);
    issue(KIND_SET_PIXEL, 8'd255, 6'd63, 1'b1, 8'hFF);
    issue(KIND_SET_PIXEL, 8'd3,   6'd40, 1'b1, 8'h81);
    issue(KIND_SET_PIXEL, 8'd0,   6'd0,  1'b0, 8'hFF);
    issue(KIND_SET_PIXEL, 8'd2,   6'd32, 1'b1, 8'h00);
    issue(KIND_WRITE8,    8'd0,   6'd0,  1'b1, 8'hA5);
    issue(KIND_WRITE8,    8'd124, 6'd9,  1'b0, 8'hFF);
    issue(KIND_WRITE8,    8'd127, 6'd31, 1'b1, 8'hFF);
    issue(KIND_WRITE8,    8'd200, 6'd10, 1'b0, 8'hFF);
    issue(KIND_WRITE8,    8'd5,   6'd50, 1'b1, 8'hFF);
    issue(KIND_WRITE8,    8'd16,  6'd7,  1'b1, 8'h00);
    issue(KIND_WRITE8,    8'd1,   6'd0,  1'b0, 8'h7E);
    pull_bytes(5);
    // clear mid-page; the stream must carry on from the same cursor
    issue(KIND_CLEAR, 8'hFF, 6'h3F, 1'b1, 8'hFF);
    pull_bytes(3);
    issue(KIND_SET_PIXEL, 8'd6, 6'd1, 1'b1, 8'hC3);
    pull_bytes(2);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      // hold off until the stream has caught up
      drain();
      while (total_sent < 25 + 130 * (ph + 1) ||
             (ph == 3 && sent_by_kind[KIND_REFRESH] < 530)) begin
        case ($urandom_range(99)) inside
          [0:34]:  repeat ($urandom_range(6, 1)) draw_request();
          [35:96]: pull_bytes($urandom_range(40, 4));
          default: issue(KIND_CLEAR, 8'($urandom), 6'($urandom), 1'($urandom), 8'($urandom));
        endcase
      end
    end

    drain();
    // let a trailing clear run out
    repeat (STORE_BYTES + 100) @(posedge clk);

    $display("Covered %0d requests: %0d pixel sets, %0d eight-pixel writes, %0d clears, %0d pulls.",
             total_sent, sent_by_kind[KIND_SET_PIXEL], sent_by_kind[KIND_WRITE8],
             sent_by_kind[KIND_CLEAR], sent_by_kind[KIND_REFRESH]);
    $display("Compared %0d link bytes across %0d complete frames.", bytes_checked, frames_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
